### design/stream_message_deframer_core_macros.svh
// Assertion macros used by the checker file smd_checker.sv.
`ifndef STREAM_MESSAGE_DEFRAMER_CORE_MACROS_SVH
`define STREAM_MESSAGE_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/smd_pkg.sv
`default_nettype none

package smd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int DELIM_BYTES  = 4;
    localparam int WINDOW_MAX   = 8;

    localparam int LEN_W       = 32;
    localparam int MAXLEN_W    = 24;
    localparam int ACC_BYTES   = LEN_W / 8;
    localparam int HDR_CNT_W   = $clog2(HEADER_BYTES + 1);
    localparam int MATCH_W     = $clog2(WINDOW_MAX);
    localparam int MAX_RESULTS = DELIM_BYTES;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = MAXLEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 1'b1;

    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 24'd65535;

    // CR LF repeated
    localparam logic [7:0] DELIM_TABLE [WINDOW_MAX] = '{
        8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h0D, 8'h0A
    };

    typedef enum logic [1:0] {
        MODE_RAW    = 2'd0,
        MODE_LENGTH = 2'd1,
        MODE_DELIM  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } in_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       message_last;
        logic       empty_message;
        logic       length_error;
    } out_t;

    // One queue entry: the results caused by one accepted byte.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [RES_CNT_W-1:0]        cnt;
        logic                        last;
        logic                        empty;
        logic                        err;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

`default_nettype wire

### design/smd_front.sv
`default_nettype none

module smd_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [smd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire smd_pkg::in_t                      in_data,
    input  wire logic                              q_full,
    output smd_pkg::push_t                         push
);

    typedef enum logic {
        PH_HEADER  = 1'b0,
        PH_PAYLOAD = 1'b1
    } phase_t;

    smd_pkg::mode_t                     mode_reg;
    logic [smd_pkg::MAXLEN_W-1:0]       max_len_reg;
    phase_t                             phase_reg,     phase_next;
    logic [smd_pkg::HDR_CNT_W-1:0]      hdr_cnt_reg,   hdr_cnt_next;
    logic [smd_pkg::LEN_W-1:0]          len_acc_reg,   len_acc_next;
    logic [smd_pkg::MAXLEN_W-1:0]       remain_reg,    remain_next;
    logic [smd_pkg::MATCH_W-1:0]        match_reg,     match_next;
    logic [7:0]                         pend_byte_reg, pend_byte_next;
    logic                               pend_valid_reg, pend_valid_next;

    logic                               accept;
    logic [7:0]                         b;
    logic [smd_pkg::LEN_W-1:0]          acc;
    logic [smd_pkg::HDR_CNT_W-1:0]      cnt_inc;
    logic [smd_pkg::MAXLEN_W-1:0]       rem_dec;
    logic [smd_pkg::MATCH_W-1:0]        m_best;
    logic                               ok;
    logic [7:0]                         seq [smd_pkg::WINDOW_MAX];
    logic [7:0]                         ext [smd_pkg::WINDOW_MAX + 1];
    smd_pkg::entry_t                    entry;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_data.rx_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        len_acc_next    = len_acc_reg;
        remain_next     = remain_reg;
        match_next      = match_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        entry           = '0;
        acc             = len_acc_reg;
        cnt_inc         = hdr_cnt_reg + smd_pkg::HDR_CNT_W'(1);
        rem_dec         = remain_reg;
        m_best          = '0;
        ok              = 1'b0;

        for (int i = 0; i < smd_pkg::WINDOW_MAX; i++)
        begin
            seq[i] = (match_reg == smd_pkg::MATCH_W'(i)) ? b : smd_pkg::DELIM_TABLE[i];
        end
        ext[0] = pend_byte_reg;
        for (int i = 0; i < smd_pkg::WINDOW_MAX; i++)
        begin
            ext[i + 1] = seq[i];
        end

        // longest proper suffix of held bytes plus b that starts the delimiter
        for (int kk = 1; kk < smd_pkg::DELIM_BYTES; kk++)
        begin
            if (match_reg == smd_pkg::MATCH_W'(kk))
            begin
                for (int mm = 1; mm <= kk; mm++)
                begin
                    ok = (b == smd_pkg::DELIM_TABLE[mm - 1]);
                    for (int i = 0; i < mm - 1; i++)
                    begin
                        if (smd_pkg::DELIM_TABLE[kk + 1 - mm + i] != smd_pkg::DELIM_TABLE[i])
                        begin
                            ok = 1'b0;
                        end
                    end
                    if (ok)
                    begin
                        m_best = smd_pkg::MATCH_W'(mm);
                    end
                end
            end
        end

        unique case (mode_reg)
            smd_pkg::MODE_LENGTH:
            begin
                if (phase_reg == PH_HEADER)
                begin
                    if (int'(hdr_cnt_reg) < smd_pkg::ACC_BYTES)
                    begin
                        acc = len_acc_reg | (smd_pkg::LEN_W'(b) << {hdr_cnt_reg, 3'b000});
                    end
                    else if (b != 8'd0)
                    begin
                        acc = '1;
                    end
                    if (cnt_inc == smd_pkg::HDR_CNT_W'(smd_pkg::HEADER_BYTES))
                    begin
                        hdr_cnt_next = '0;
                        len_acc_next = '0;
                        if (acc > smd_pkg::LEN_W'(max_len_reg))
                        begin
                            entry.cnt  = smd_pkg::RES_CNT_W'(1);
                            entry.last = 1'b1;
                            entry.err  = 1'b1;
                        end
                        else if (acc == '0)
                        begin
                            entry.cnt   = smd_pkg::RES_CNT_W'(1);
                            entry.last  = 1'b1;
                            entry.empty = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_PAYLOAD;
                            remain_next = acc[smd_pkg::MAXLEN_W-1:0];
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = cnt_inc;
                        len_acc_next = acc;
                    end
                end
                else
                begin
                    if (remain_reg != '0)
                    begin
                        rem_dec = remain_reg - smd_pkg::MAXLEN_W'(1);
                    end
                    remain_next   = rem_dec;
                    entry.cnt     = smd_pkg::RES_CNT_W'(1);
                    entry.data[0] = b;
                    entry.last    = (rem_dec == '0);
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            smd_pkg::MODE_DELIM:
            begin
                if (b == smd_pkg::DELIM_TABLE[match_reg])
                begin
                    if (match_reg == smd_pkg::MATCH_W'(smd_pkg::DELIM_BYTES - 1))
                    begin
                        entry.cnt       = smd_pkg::RES_CNT_W'(1);
                        entry.last      = 1'b1;
                        entry.empty     = !pend_valid_reg;
                        entry.data[0]   = pend_valid_reg ? pend_byte_reg : 8'd0;
                        pend_valid_next = 1'b0;
                        pend_byte_next  = 8'd0;
                        match_next      = '0;
                    end
                    else
                    begin
                        match_next = match_reg + smd_pkg::MATCH_W'(1);
                    end
                end
                else
                begin
                    entry.cnt = smd_pkg::RES_CNT_W'(match_reg - m_best)
                              + smd_pkg::RES_CNT_W'(pend_valid_reg);
                    for (int j = 0; j < smd_pkg::MAX_RESULTS; j++)
                    begin
                        entry.data[j] = pend_valid_reg ? ext[j] : ext[j + 1];
                    end
                    pend_byte_next  = (m_best == '0) ? b
                                    : smd_pkg::DELIM_TABLE[match_reg - m_best];
                    pend_valid_next = 1'b1;
                    match_next      = m_best;
                end
            end
            default:
            begin
                entry.cnt     = smd_pkg::RES_CNT_W'(1);
                entry.data[0] = b;
                entry.last    = in_data.chunk_end;
            end
        endcase
    end

    assign push.valid = accept && (entry.cnt != '0);
    assign push.entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= smd_pkg::MODE_RAW;
            max_len_reg    <= smd_pkg::MAX_LEN_RESET;
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            len_acc_reg    <= '0;
            remain_reg     <= '0;
            match_reg      <= '0;
            pend_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cfg_we && (cfg_index == smd_pkg::REG_FRAME_MODE))
        begin
            mode_reg       <= smd_pkg::mode_t'(cfg_data[1:0]);
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            len_acc_reg    <= '0;
            remain_reg     <= '0;
            match_reg      <= '0;
            pend_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cfg_we && (cfg_index == smd_pkg::REG_MAX_LEN))
        begin
            max_len_reg <= cfg_data;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            len_acc_reg    <= len_acc_next;
            remain_reg     <= remain_next;
            match_reg      <= match_next;
            pend_byte_reg  <= pend_byte_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/smd_queue.sv
`default_nettype none

module smd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smd_pkg::push_t   push,
    output logic                  full,
    input  wire logic             pop,
    output smd_pkg::head_t        head
);

    smd_pkg::entry_t                 mem_reg [smd_pkg::FIFO_DEPTH];
    logic [smd_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [smd_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [smd_pkg::FIFO_CNT_W-1:0]  count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == smd_pkg::FIFO_CNT_W'(smd_pkg::FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + smd_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + smd_pkg::FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + smd_pkg::FIFO_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - smd_pkg::FIFO_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### design/smd_back.sv
`default_nettype none

module smd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire smd_pkg::head_t   head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output smd_pkg::out_t         out_data
);

    logic [smd_pkg::RES_IDX_W-1:0]  idx_reg;
    logic                           out_valid_reg;
    smd_pkg::out_t                  out_data_reg;
    smd_pkg::out_t                  out_data_next;
    logic                           load;
    logic                           idx_last;

    assign load     = head.valid && (!out_valid_reg || !out_stall);
    assign idx_last = (smd_pkg::RES_CNT_W'(idx_reg) + smd_pkg::RES_CNT_W'(1)) == head.entry.cnt;
    assign pop      = load && idx_last;

    always_comb
    begin
        out_data_next.payload_byte  = head.entry.data[idx_reg];
        out_data_next.message_last  = idx_last && head.entry.last;
        out_data_next.empty_message = head.entry.empty;
        out_data_next.length_error  = head.entry.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_last ? '0 : idx_reg + smd_pkg::RES_IDX_W'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### design/stream_message_deframer_core.sv
// Stream message deframer.
// Input channel (in_valid/in_stall/in_data): one received byte per transaction,
// with chunk_end marking the last byte of a received chunk.
// Output channel (out_valid/out_stall/out_data): one message byte, or an empty
// or length-error marker, per transaction; message_last ends a message.
// Config port: cfg_we/cfg_index/cfg_data; index 0 frame_mode, 1 max_payload_length.
// Write only while idle; a frame_mode write drops any partial frame.
// Each accepted byte's results enter the queue, then load into the output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver does not stall. A byte that releases n held delimiter candidates
// sends them through the output stage one at a time; a 4-entry queue between the
// classifier and the output stage absorbs these bursts, and the output register
// sets the one-result-per-cycle rate. Receiver stall: the output register holds,
// the queue fills, and in_stall rises once the queue is full.
// Reset: mode 0 (pass-through), max_payload_length 65535, queue empty.
`default_nettype none

module stream_message_deframer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [smd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire smd_pkg::in_t                      in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output smd_pkg::out_t                          out_data
);

    smd_pkg::push_t  push;
    smd_pkg::head_t  head;
    logic            q_full;
    logic            pop;

    smd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push)
    );

    smd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    smd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### design/smd_checker.sv
`default_nettype none

`include "stream_message_deframer_core_macros.svh"

module smd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire smd_pkg::out_t                     out_data
);

    logic in_fire;
    logic out_marker;
    logic marker_ok;

    assign in_fire    = in_valid && !in_stall;
    assign out_marker = out_valid && (out_data.empty_message || out_data.length_error);
    assign marker_ok  = out_data.message_last && (out_data.payload_byte == 8'd0);

    `SMD_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid, "out_valid dropped")
    `SMD_ASSERT_NEXT(a_out_data_held, out_valid && out_stall, $stable(out_data), "out_data moved")
    `SMD_ASSERT_NOW(a_rise_needs_input, $rose(out_valid), $past(in_fire, 2), "result w/o input")
    `SMD_ASSERT_NOW(a_stall_needs_output, in_stall, out_valid, "input stalled with output idle")
    `SMD_ASSERT_NOW(a_marker_is_last, out_marker, marker_ok, "marker result malformed")

endmodule

bind stream_message_deframer_core smd_checker u_smd_checker (.*);

`default_nettype wire
